// ===== sv/arsc_pkg.sv =====
package arsc_pkg;

  localparam int unsigned TimeWidth    = 20;
  localparam int unsigned ScaleWidth   = 16;
  localparam int unsigned AvgWidth     = 36;
  localparam int unsigned FracBits     = 16;
  localparam int unsigned CountWidth   = 17;
  localparam int unsigned HoldWidth    = 16;
  localparam int unsigned LimitWidth   = 40;
  localparam int unsigned CfgDataWidth = 20;
  localparam int unsigned CfgIdxWidth  = 3;

  localparam logic [ScaleWidth-1:0] ScaleOne = 16'd32768;
  localparam logic [CountWidth-1:0] CountMax = 17'd131071;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_SMOOTHING_WEIGHT = 3'd0,
    REG_WARMUP_FRAMES    = 3'd1,
    REG_TARGET_TIME      = 3'd2,
    REG_DOWN_FACTOR      = 3'd3,
    REG_UP_FACTOR        = 3'd4,
    REG_SCALE_FLOOR      = 3'd5,
    REG_SCALE_STEP       = 3'd6,
    REG_HOLD_FRAMES      = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]          smoothing_weight;
    logic [15:0]          warmup_frames;
    logic [TimeWidth-1:0] target_time;
    logic [15:0]          down_factor;
    logic [15:0]          up_factor;
    logic [15:0]          scale_floor;
    logic [15:0]          scale_step;
    logic [15:0]          hold_frames;
  } cfg_regs_t;

  localparam cfg_regs_t CfgReset = '{
    smoothing_weight: 16'd6554,
    warmup_frames:    16'd30,
    target_time:      20'd4267,
    down_factor:      16'd4506,
    up_factor:        16'd3277,
    scale_floor:      16'd16384,
    scale_step:       16'd1638,
    hold_frames:      16'd30
  };

endpackage

// ===== sv/adaptive_render_scale_controller_unit.sv =====
// Adaptive render scale controller. Each item is one measured frame time in 1/256 ms
// (zero is ignored); each item returns exactly one render scale in Q1.15. One item is
// accepted every cycle while the output is not stalled. The result passes through the input
// register and then the result register, and is held in the result register until taken; while
// it waits, one more item can sit in the input register before the input stalls. The per-frame
// state update (moving average, counters and scale) is combinational and is registered as the
// result is, so the next frame sees it. Configuration writes take effect at the next
// clock edge.
module adaptive_render_scale_controller_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [arsc_pkg::TimeWidth-1:0]      frame_time,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [arsc_pkg::ScaleWidth-1:0]     render_scale,
  input  logic                                cfg_write,
  input  logic [arsc_pkg::CfgIdxWidth-1:0]    cfg_index,
  input  logic [arsc_pkg::CfgDataWidth-1:0]   cfg_data
);

  arsc_pkg::cfg_regs_t cfg;

  logic                              s1_valid;
  logic [arsc_pkg::TimeWidth-1:0]    s1_time;
  logic                              advance;

  logic [arsc_pkg::ScaleWidth-1:0]   current_scale;
  logic [arsc_pkg::AvgWidth-1:0]     average_time;
  logic [arsc_pkg::CountWidth-1:0]   frame_count;
  logic [arsc_pkg::HoldWidth-1:0]    hold_count;

  logic [arsc_pkg::ScaleWidth-1:0]   current_scale_next;
  logic [arsc_pkg::AvgWidth-1:0]     average_time_next;
  logic [arsc_pkg::CountWidth-1:0]   frame_count_next;
  logic [arsc_pkg::HoldWidth-1:0]    hold_count_next;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= arsc_pkg::CfgReset;
    end else if (cfg_write) begin
      unique case (arsc_pkg::cfg_reg_t'(cfg_index))
        arsc_pkg::REG_SMOOTHING_WEIGHT: cfg.smoothing_weight <= cfg_data[15:0];
        arsc_pkg::REG_WARMUP_FRAMES:    cfg.warmup_frames    <= cfg_data[15:0];
        arsc_pkg::REG_TARGET_TIME:      cfg.target_time      <= cfg_data;
        arsc_pkg::REG_DOWN_FACTOR:      cfg.down_factor      <= cfg_data[15:0];
        arsc_pkg::REG_UP_FACTOR:        cfg.up_factor        <= cfg_data[15:0];
        arsc_pkg::REG_SCALE_FLOOR:      cfg.scale_floor      <= cfg_data[15:0];
        arsc_pkg::REG_SCALE_STEP:       cfg.scale_step       <= cfg_data[15:0];
        arsc_pkg::REG_HOLD_FRAMES:      cfg.hold_frames      <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_time <= frame_time;
    end
  end

  // state update
  always_comb begin
    logic [arsc_pkg::AvgWidth-1:0]    sample;
    logic [arsc_pkg::AvgWidth-1:0]    diff;
    logic [arsc_pkg::AvgWidth+15:0]   prod;
    logic [arsc_pkg::AvgWidth-1:0]    delta;
    logic [arsc_pkg::TimeWidth+15:0]  down_prod;
    logic [arsc_pkg::TimeWidth+15:0]  up_prod;
    logic [arsc_pkg::LimitWidth-1:0]  down_lim;
    logic [arsc_pkg::LimitWidth-1:0]  up_lim;
    logic [arsc_pkg::LimitWidth-1:0]  avg_ext;
    logic [arsc_pkg::ScaleWidth-1:0]  floor_eff;
    logic [arsc_pkg::ScaleWidth-1:0]  lowered;
    logic [arsc_pkg::ScaleWidth:0]    raised;
    logic                             rising;

    current_scale_next = current_scale;
    average_time_next  = average_time;
    frame_count_next   = frame_count;
    hold_count_next    = hold_count;

    sample = {s1_time, {arsc_pkg::FracBits{1'b0}}};
    rising = sample >= average_time;
    diff   = rising ? sample - average_time : average_time - sample;
    prod   = {{arsc_pkg::FracBits{1'b0}}, diff} *
             {{arsc_pkg::AvgWidth{1'b0}}, cfg.smoothing_weight};
    delta  = prod[arsc_pkg::AvgWidth+15:arsc_pkg::FracBits];

    down_prod = {16'b0, cfg.target_time} * {{arsc_pkg::TimeWidth{1'b0}}, cfg.down_factor};
    up_prod   = {16'b0, cfg.target_time} * {{arsc_pkg::TimeWidth{1'b0}}, cfg.up_factor};
    down_lim  = {down_prod, 4'b0000};
    up_lim    = {up_prod, 4'b0000};

    floor_eff = (cfg.scale_floor > arsc_pkg::ScaleOne) ? arsc_pkg::ScaleOne : cfg.scale_floor;
    lowered   = (current_scale > cfg.scale_step) ? current_scale - cfg.scale_step : '0;
    raised    = {1'b0, current_scale} + {1'b0, cfg.scale_step};

    if (s1_time != '0) begin
      if (frame_count == '0) begin
        average_time_next = sample;
      end else begin
        average_time_next = rising ? average_time + delta : average_time - delta;
      end
      if (frame_count < arsc_pkg::CountMax) begin
        frame_count_next = frame_count + arsc_pkg::CountWidth'(1);
      end
      avg_ext = {{(arsc_pkg::LimitWidth-arsc_pkg::AvgWidth){1'b0}}, average_time_next};

      if (hold_count != '0) begin
        hold_count_next = hold_count - arsc_pkg::HoldWidth'(1);
      end else if (frame_count_next > {1'b0, cfg.warmup_frames}) begin
        if (avg_ext > down_lim) begin
          current_scale_next = (lowered < floor_eff) ? floor_eff : lowered;
          hold_count_next    = cfg.hold_frames;
        end else if (avg_ext < up_lim) begin
          current_scale_next = (raised > {1'b0, arsc_pkg::ScaleOne}) ?
                               arsc_pkg::ScaleOne : raised[arsc_pkg::ScaleWidth-1:0];
          hold_count_next    = cfg.hold_frames;
        end
      end
    end else begin
      avg_ext = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_scale <= arsc_pkg::ScaleOne;
      average_time  <= '0;
      frame_count   <= '0;
      hold_count    <= '0;
    end else if (s1_valid && advance) begin
      current_scale <= current_scale_next;
      average_time  <= average_time_next;
      frame_count   <= frame_count_next;
      hold_count    <= hold_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && advance) begin
      render_scale <= current_scale_next;
    end
  end

  scale_capped: assert property (@(posedge clk) disable iff (rst)
    current_scale <= arsc_pkg::ScaleOne)
    else $error("render scale above 1.0");

  result_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> render_scale == current_scale)
    else $error("held result differs from current scale");

  unseeded_is_clean: assert property (@(posedge clk) disable iff (rst)
    frame_count == '0 |-> hold_count == '0 && current_scale == arsc_pkg::ScaleOne)
    else $error("scale changed before any valid frame");

  count_never_wraps: assert property (@(posedge clk) disable iff (rst)
    frame_count != '0 |=> frame_count != '0)
    else $error("frame count returned to zero");

  stalled_item_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !advance |=> s1_valid && $stable(s1_time))
    else $error("input register lost an item during stall");

endmodule

// ===== bench/adaptive_render_scale_controller_unit_test.sv =====
module adaptive_render_scale_controller_unit_test;

  localparam int StallLimit = 4000;
  localparam int SubphaseItems = 140;
  localparam int MaxPrinted = 50;
  localparam int CfgBits = $bits(arsc_pkg::cfg_regs_t);
  localparam logic [arsc_pkg::TimeWidth-1:0] TimeMax = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [arsc_pkg::TimeWidth-1:0] frame_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [arsc_pkg::ScaleWidth-1:0] render_scale;
  logic cfg_write = 1'b0;
  logic [arsc_pkg::CfgIdxWidth-1:0] cfg_index = '0;
  logic [arsc_pkg::CfgDataWidth-1:0] cfg_data = '0;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int mismatches = 0;

  // mirror of the block state
  arsc_pkg::cfg_regs_t mirror_cfg;
  logic [arsc_pkg::ScaleWidth-1:0] cur_scale;
  logic [arsc_pkg::AvgWidth-1:0] avg_time;
  logic [arsc_pkg::CountWidth-1:0] seen_frames;
  logic [arsc_pkg::HoldWidth-1:0] hold_left;
  logic [arsc_pkg::ScaleWidth-1:0] expected_scales[$];
  logic [arsc_pkg::ScaleWidth-1:0] oldest_scale;
  logic [arsc_pkg::ScaleWidth-1:0] newest_scale;

  // stimulus shaping
  arsc_pkg::cfg_regs_t plan;
  bit slow_run = 1'b0;

  adaptive_render_scale_controller_unit u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .frame_time(frame_time),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .render_scale(render_scale),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= receiver_stall_pct);
  end

  function automatic logic [arsc_pkg::ScaleWidth-1:0] next_render_scale(
      input logic [arsc_pkg::TimeWidth-1:0] t);
    logic [63:0] sample;
    logic [63:0] weight;
    logic [63:0] down_lim;
    logic [63:0] up_lim;
    logic [16:0] fl;
    logic [16:0] lowered;
    logic [16:0] raised;
    if (t != '0) begin
      sample = 64'(t) << arsc_pkg::FracBits;
      weight = 64'(mirror_cfg.smoothing_weight);
      if (seen_frames == '0) begin
        avg_time = sample[arsc_pkg::AvgWidth-1:0];
      end else if (sample >= 64'(avg_time)) begin
        avg_time = avg_time +
                   arsc_pkg::AvgWidth'((weight * (sample - 64'(avg_time))) >> 16);
      end else begin
        avg_time = avg_time -
                   arsc_pkg::AvgWidth'((weight * (64'(avg_time) - sample)) >> 16);
      end
      if (seen_frames < arsc_pkg::CountMax) seen_frames = seen_frames + 1'b1;

      if (hold_left != '0) begin
        hold_left = hold_left - 1'b1;
      end else if (seen_frames > 17'(mirror_cfg.warmup_frames)) begin
        down_lim = (64'(mirror_cfg.target_time) * 64'(mirror_cfg.down_factor)) << 4;
        up_lim = (64'(mirror_cfg.target_time) * 64'(mirror_cfg.up_factor)) << 4;
        if (64'(avg_time) > down_lim) begin
          fl = (mirror_cfg.scale_floor > arsc_pkg::ScaleOne) ?
               17'(arsc_pkg::ScaleOne) : 17'(mirror_cfg.scale_floor);
          lowered = (cur_scale > mirror_cfg.scale_step) ?
                    17'(cur_scale - mirror_cfg.scale_step) : '0;
          cur_scale = arsc_pkg::ScaleWidth'((lowered < fl) ? fl : lowered);
          hold_left = mirror_cfg.hold_frames;
        end else if (64'(avg_time) < up_lim) begin
          raised = 17'(cur_scale) + 17'(mirror_cfg.scale_step);
          cur_scale = (raised > 17'(arsc_pkg::ScaleOne)) ?
                      arsc_pkg::ScaleOne : arsc_pkg::ScaleWidth'(raised);
          hold_left = mirror_cfg.hold_frames;
        end
      end
    end
    return cur_scale;
  endfunction

  task automatic report_mismatch(input string what,
                                 input logic [arsc_pkg::ScaleWidth-1:0] got,
                                 input logic [arsc_pkg::ScaleWidth-1:0] want);
    mismatches++;
    if (mismatches <= MaxPrinted)
      $display("mismatch: %s: render_scale got %0d expected %0d", what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mirror_cfg = arsc_pkg::CfgReset;
      cur_scale = arsc_pkg::ScaleOne;
      avg_time = '0;
      seen_frames = '0;
      hold_left = '0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_scales.size() == 0) begin
          report_mismatch("item with nothing expected", render_scale, '0);
        end else begin
          oldest_scale = expected_scales.pop_front();
          if (render_scale !== oldest_scale)
            report_mismatch("wrong scale", render_scale, oldest_scale);
        end
      end
      if (cfg_write) begin
        case (arsc_pkg::cfg_reg_t'(cfg_index))
          arsc_pkg::REG_SMOOTHING_WEIGHT: mirror_cfg.smoothing_weight = cfg_data[15:0];
          arsc_pkg::REG_WARMUP_FRAMES:    mirror_cfg.warmup_frames = cfg_data[15:0];
          arsc_pkg::REG_TARGET_TIME:      mirror_cfg.target_time = cfg_data;
          arsc_pkg::REG_DOWN_FACTOR:      mirror_cfg.down_factor = cfg_data[15:0];
          arsc_pkg::REG_UP_FACTOR:        mirror_cfg.up_factor = cfg_data[15:0];
          arsc_pkg::REG_SCALE_FLOOR:      mirror_cfg.scale_floor = cfg_data[15:0];
          arsc_pkg::REG_SCALE_STEP:       mirror_cfg.scale_step = cfg_data[15:0];
          arsc_pkg::REG_HOLD_FRAMES:      mirror_cfg.hold_frames = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        newest_scale = next_render_scale(frame_time);
        expected_scales = {expected_scales, newest_scale};
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("adaptive_render_scale_controller_unit_test: done, errors");
    $finish;
  end

  task automatic send_frame(input logic [arsc_pkg::TimeWidth-1:0] t);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    frame_time = t;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_scales.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input arsc_pkg::cfg_reg_t idx,
                                input logic [arsc_pkg::CfgDataWidth-1:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
  endtask

  task automatic program_settings(input arsc_pkg::cfg_regs_t s);
    logic [3:0] junk;
    junk = 4'($urandom);
    plan = s;
    write_register(arsc_pkg::REG_SMOOTHING_WEIGHT, {junk, s.smoothing_weight});
    write_register(arsc_pkg::REG_WARMUP_FRAMES, {~junk, s.warmup_frames});
    write_register(arsc_pkg::REG_TARGET_TIME, s.target_time);
    write_register(arsc_pkg::REG_DOWN_FACTOR, {junk, s.down_factor});
    write_register(arsc_pkg::REG_UP_FACTOR, {~junk, s.up_factor});
    write_register(arsc_pkg::REG_SCALE_FLOOR, {junk, s.scale_floor});
    write_register(arsc_pkg::REG_SCALE_STEP, {~junk, s.scale_step});
    write_register(arsc_pkg::REG_HOLD_FRAMES, {junk, s.hold_frames});
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  function automatic arsc_pkg::cfg_regs_t random_settings(input int k);
    arsc_pkg::cfg_regs_t s;
    logic [159:0] raw;
    s.smoothing_weight = 16'($urandom_range(65535, 3000));
    s.warmup_frames = 16'($urandom_range(12));
    s.target_time = 20'($urandom_range(200000, 500));
    s.down_factor = 16'($urandom_range(8192, 4096));
    s.up_factor = 16'($urandom_range(4096, 1024));
    s.scale_floor = 16'($urandom_range(32768));
    s.scale_step = 16'($urandom_range(8000, 1));
    s.hold_frames = 16'($urandom_range(6));
    case (k)
      1: begin
        s.target_time = TimeMax;
        s.down_factor = 16'hFFFF;
        s.up_factor = 16'hFFFF;
      end
      3: begin
        s.target_time = '0;
        s.scale_floor = '0;
        s.scale_step = 16'd32768;
      end
      5: begin
        s.hold_frames = 16'hFFFF;
        s.smoothing_weight = '0;
      end
      6: begin
        s.down_factor = '0;
        s.up_factor = '0;
        s.warmup_frames = '0;
        s.smoothing_weight = 16'hFFFF;
        s.scale_floor = 16'hFFFF;
      end
      7: begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        s = arsc_pkg::cfg_regs_t'(raw[CfgBits-1:0]);
        s.warmup_frames = 16'($urandom_range(20));
        s.hold_frames = 16'($urandom_range(10));
      end
      default: ;
    endcase
    return s;
  endfunction

  // times mostly wander in runs above the drop limit and below the raise limit
  function automatic logic [arsc_pkg::TimeWidth-1:0] pick_frame_time();
    int unsigned r;
    longint down_thr;
    longint up_thr;
    longint base;
    longint span;
    longint t;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 14) return arsc_pkg::TimeWidth'($urandom);
    if (r < 16) return (r == 14) ? TimeMax : arsc_pkg::TimeWidth'(1);
    if ($urandom_range(11) == 0) slow_run = ~slow_run;
    down_thr = (longint'(plan.target_time) * longint'(plan.down_factor)) >>> 12;
    up_thr = (longint'(plan.target_time) * longint'(plan.up_factor)) >>> 12;
    base = slow_run ? down_thr + down_thr / 8 + 2 : up_thr - up_thr / 8 - 1;
    span = base / 16 + 1;
    if (span > 100000) span = 100000;
    t = base + longint'($urandom_range(2 * int'(span))) - span;
    if (t < 1) t = 1;
    if (t > longint'(TimeMax)) t = longint'(TimeMax);
    return arsc_pkg::TimeWidth'(t);
  endfunction

  task automatic test_directed_corners();
    send_frame('0);
    send_frame(TimeMax);
    settle();
    // floor above 1.0 with a full step, short hold
    program_settings('{smoothing_weight: 16'hFFFF, warmup_frames: 16'd0,
                       target_time: 20'd1000, down_factor: 16'd4096, up_factor: 16'd4096,
                       scale_floor: 16'hFFFF, scale_step: 16'd32768, hold_frames: 16'd2});
    send_frame(TimeMax);
    send_frame(TimeMax);
    send_frame(TimeMax);
    send_frame('0);
    settle();
    // step larger than scale, then raise past 1.0
    program_settings('{smoothing_weight: 16'hFFFF, warmup_frames: 16'd0,
                       target_time: 20'd1000, down_factor: 16'd4096, up_factor: 16'd4096,
                       scale_floor: 16'd0, scale_step: 16'hFFFF, hold_frames: 16'd0});
    send_frame(TimeMax);
    send_frame(TimeMax);
    send_frame(20'd1);
    send_frame(20'd1);
    settle();
    // zero limits always drop, down to the floor
    program_settings('{smoothing_weight: 16'd6554, warmup_frames: 16'd0,
                       target_time: 20'd0, down_factor: 16'd0, up_factor: 16'd0,
                       scale_floor: 16'd16384, scale_step: 16'd5000, hold_frames: 16'd0});
    repeat (4) send_frame(TimeMax);
    settle();
    // frozen average, hold of one, warmup already passed
    program_settings('{smoothing_weight: 16'd0, warmup_frames: 16'd3,
                       target_time: 20'd4267, down_factor: 16'd4506, up_factor: 16'd3277,
                       scale_floor: 16'd16384, scale_step: 16'd1638, hold_frames: 16'd1});
    send_frame(TimeMax);
    send_frame(TimeMax);
    send_frame(20'd524288);
    send_frame(20'd1);
    settle();
  endtask

  task automatic test_random_settings();
    for (int k = 0; k < 8; k++) begin
      case (k / 2)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
        default: begin sender_idle_pct = 36; receiver_stall_pct = 36; end
      endcase
      program_settings(random_settings(k));
      for (int n = 0; n < SubphaseItems; n++) send_frame(pick_frame_time());
      settle();
    end
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_corners();
    test_random_settings();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_scales.size() == 0) begin
      $display("adaptive_render_scale_controller_unit_test: done, clean");
    end else begin
      $display("adaptive_render_scale_controller_unit_test: done, errors");
    end
    $finish;
  end

endmodule
